@@ design/heightmap_to_normalmap_unit_defines.svh @@
// Assertion macros shared by the checker of the height map to normal map unit.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef HEIGHTMAP_TO_NORMALMAP_UNIT_DEFINES_SVH
`define HEIGHTMAP_TO_NORMALMAP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HNM_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("hnm checker: same-cycle property failed");

// Next-cycle implication, disabled while in reset.
`define HNM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("hnm checker: next-cycle property failed");

`endif

@@ design/hnm_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the
// height map to normal map unit. No dependencies.
package hnm_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int HEIGHT_BITS_DEF = 8;
    localparam int NORMAL_BITS_DEF = 8;

    localparam int FW_W    = 13;
    localparam int FH_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 16;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 4;

    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 13'd1024;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 16'd1024;
    localparam logic [GAIN_W-1:0] GAIN_X_RST       = 16'd1028;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST       = 16'd1028;

    // Unit z component in Q16
    localparam int Z_ONE = 65536;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_GAIN_X,
        REG_GAIN_Y
    } t_reg;

    // Which neighbour pair one normal is built from
    typedef enum logic [1:0] {
        JOB_ABOVE,
        JOB_LEFT,
        JOB_CORNER
    } t_job;

    typedef struct packed {
        logic [FW_W-1:0]   frame_width;
        logic [FH_W-1:0]   frame_height;
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_y;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic rd_next;
        logic cap_above;
        logic cap_right;
        logic start;
        t_job job;
        logic last;
        logic push;
        logic write_back;
    } t_cmd;

    typedef struct packed {
        logic has_above;
        logic last_row;
        logic x_nonzero;
        logic end_row;
        logic norm_done;
        logic out_free;
    } t_sts;

endpackage

@@ design/heightmap_to_normalmap_unit.sv @@
// Height map to normal map unit: height pixels in raster order in, one
// normal per pixel out, with its column and row. An item on the first row
// gives no result unless that row is also the last; other items give k
// results (one on most rows, up to three on the last): per result the
// shared normal unit runs two gain multiplies, three squares, a 31-step
// square root and three NORMAL_BITS-step divisions, and the line store is
// read twice and written once per item over its single read port.
// A finished result waits in the output register while the next item is taken.
// Configuration registers sit behind the APB port at 0x0 (frame width),
// 0x4 (frame height), 0x8 (gain x) and 0xC (gain y).
module heightmap_to_normalmap_unit #(
    parameter int MAX_WIDTH   = hnm_pkg::MAX_WIDTH_DEF,
    parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS_DEF,
    parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF,
    localparam int IN_DATA_W  = ((HEIGHT_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W =
        ((3 * NORMAL_BITS + hnm_pkg::COL_W + hnm_pkg::ROW_W + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hnm_pkg::PADDR_W-1:0]  paddr,
    input  logic [hnm_pkg::APB_W-1:0]    pwdata,
    output logic [hnm_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: height
    input  logic [IN_DATA_W-1:0]         s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: normal_x, normal_y, normal_z, out_col, out_row
    output logic [OUT_DATA_W-1:0]        m_tdata,
    // m_tlast: last_of_item
    output logic                         m_tlast,
    // m_tuser: frame_done
    output logic [0:0]                   m_tuser
);
    import hnm_pkg::*;

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [GAIN_W-1:0] r_gain_x, r_gain_y;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    t_reg w_reg;

    logic [NORMAL_BITS-1:0] w_nx, w_ny, w_nz;
    logic [COL_W-1:0]       w_col;
    logic [ROW_W-1:0]       w_row;

    assign w_reg  = t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_gain_x       <= GAIN_X_RST;
            r_gain_y       <= GAIN_Y_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                REG_GAIN_X:       r_gain_x       <= pwdata[GAIN_W-1:0];
                REG_GAIN_Y:       r_gain_y       <= pwdata[GAIN_W-1:0];
                default:          r_gain_y       <= r_gain_y;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_FRAME_WIDTH:  prdata = APB_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_W'(r_frame_height);
            REG_GAIN_X:       prdata = APB_W'(r_gain_x);
            REG_GAIN_Y:       prdata = APB_W'(r_gain_y);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.frame_width  = r_frame_width;
        w_cfg.frame_height = r_frame_height;
        w_cfg.gain_x       = r_gain_x;
        w_cfg.gain_y       = r_gain_y;
    end

    hnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hnm_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .HEIGHT_BITS (HEIGHT_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_height       (s_tdata[HEIGHT_BITS-1:0]),
        .o_out_valid    (m_tvalid),
        .i_out_ready    (m_tready),
        .o_normal_x     (w_nx),
        .o_normal_y     (w_ny),
        .o_normal_z     (w_nz),
        .o_out_col      (w_col),
        .o_out_row      (w_row),
        .o_last_of_item (m_tlast),
        .o_frame_done   (m_tuser[0])
    );

    assign m_tdata = OUT_DATA_W'({w_row, w_col, w_nz, w_ny, w_nx});

endmodule

@@ design/hnm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hnm_normal.sv @@
// Iterative normal unit: gain multiply, range shift, sum of squares,
// bit-pair square root and three restoring divisions. Uses hnm_pkg.
module hnm_normal #(
    parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS_DEF,
    parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [HEIGHT_BITS:0]   i_dx,
    input  logic signed [HEIGHT_BITS:0]   i_dy,
    input  logic [hnm_pkg::GAIN_W-1:0]    i_gain_x,
    input  logic [hnm_pkg::GAIN_W-1:0]    i_gain_y,
    output logic                          o_done,
    output logic [NORMAL_BITS-1:0]        o_nx,
    output logic [NORMAL_BITS-1:0]        o_ny,
    output logic [NORMAL_BITS-1:0]        o_nz
);
    import hnm_pkg::*;

    localparam int HB    = HEIGHT_BITS;
    localparam int NB    = NORMAL_BITS;
    localparam int DW    = HB + 1;
    localparam int SQ_W  = 63;
    localparam int REM_W = 34 + NB;
    localparam int KW    = $clog2(NB);

    typedef enum logic [3:0] {
        N_IDLE, N_MUL_A, N_MUL_B, N_SCALE, N_SQ, N_SQRT,
        N_DIV_LOAD, N_DIV, N_STORE, N_DONE
    } t_state;

    t_state           r_state;
    logic [HB-1:0]    r_mag_a, r_mag_b;
    logic             r_neg_a, r_neg_b;
    logic [31:0]      r_ua, r_ub;
    logic [29:0]      r_va, r_vb, r_vz;
    logic [1:0]       r_sq_idx;
    logic [SQ_W-1:0]  r_acc, r_root, r_bit;
    logic [1:0]       r_comp;
    logic [REM_W-1:0] r_rem, r_div;
    logic [NB-1:0]    r_q;
    logic [KW-1:0]    r_k;
    logic [NB-1:0]    r_nx, r_ny, r_nz;

    logic [29:0]        w_op_a, w_op_b;
    logic [59:0]        w_prod;
    logic [31:0]        w_m, w_ua_sh, w_ub_sh, w_uz_sh;
    logic [1:0]         w_shamt;
    logic [SQ_W-1:0]    w_trial;
    logic               w_sqrt_ge;
    logic [29:0]        w_cmag;
    logic               w_cneg;
    logic signed [33:0] w_c, w_v;
    logic               w_vpos;
    logic [32:0]        w_vu;
    logic [REM_W-1:0]   w_num, w_div_init;
    logic               w_div_ge;
    logic signed [DW-1:0] w_ndx, w_ndy;

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            N_MUL_A: begin
                w_op_a = 30'(i_gain_x);
                w_op_b = 30'(r_mag_a);
            end
            N_MUL_B: begin
                w_op_a = 30'(i_gain_y);
                w_op_b = 30'(r_mag_b);
            end
            N_SQ: begin
                case (r_sq_idx)
                    2'd0:    w_op_a = r_va;
                    2'd1:    w_op_a = r_vb;
                    default: w_op_a = r_vz;
                endcase
                w_op_b = w_op_a;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // Smallest shift that brings every component below 2^30
    always_comb begin
        w_m     = r_ua | r_ub;
        w_shamt = w_m[31] ? 2'd2 : (w_m[30] ? 2'd1 : 2'd0);
        w_ua_sh = r_ua >> w_shamt;
        w_ub_sh = r_ub >> w_shamt;
        w_uz_sh = 32'(Z_ONE) >> w_shamt;
    end

    assign w_trial   = r_root + r_bit;
    assign w_sqrt_ge = (r_acc >= w_trial);

    always_comb begin
        case (r_comp)
            2'd0: begin
                w_cmag = r_va;
                w_cneg = r_neg_a;
            end
            2'd1: begin
                w_cmag = r_vb;
                w_cneg = r_neg_b;
            end
            default: begin
                w_cmag = r_vz;
                w_cneg = 1'b0;
            end
        endcase
        w_c        = w_cneg ? -$signed({4'd0, w_cmag}) : $signed({4'd0, w_cmag});
        w_v        = w_c + $signed({2'd0, r_root[31:0]});
        w_vpos     = !w_v[33] && (w_v != '0);
        w_vu       = w_v[32:0];
        // v * (2^NB - 1) without a multiplier
        w_num      = REM_W'({w_vu, {NB{1'b0}}}) - REM_W'(w_vu);
        w_div_init = REM_W'({r_root[31:0], 1'b0}) << (NB - 1);
    end

    assign w_div_ge = (r_rem >= r_div);
    assign w_ndx    = -i_dx;
    assign w_ndy    = -i_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            if (i_start) begin
                // a = -gain*dx is negative when dx is positive
                r_neg_a <= !i_dx[DW-1] && (i_dx != '0);
                r_neg_b <= !i_dy[DW-1] && (i_dy != '0);
                r_mag_a <= i_dx[DW-1] ? w_ndx[HB-1:0] : i_dx[HB-1:0];
                r_mag_b <= i_dy[DW-1] ? w_ndy[HB-1:0] : i_dy[HB-1:0];
                r_state <= N_MUL_A;
            end else begin
                unique case (r_state)
                    N_IDLE: r_state <= N_IDLE;
                    N_MUL_A: begin
                        r_ua    <= w_prod[31:0];
                        r_state <= N_MUL_B;
                    end
                    N_MUL_B: begin
                        r_ub    <= w_prod[31:0];
                        r_state <= N_SCALE;
                    end
                    N_SCALE: begin
                        r_va     <= w_ua_sh[29:0];
                        r_vb     <= w_ub_sh[29:0];
                        r_vz     <= w_uz_sh[29:0];
                        r_acc    <= '0;
                        r_sq_idx <= 2'd0;
                        r_state  <= N_SQ;
                    end
                    N_SQ: begin
                        r_acc <= r_acc + SQ_W'(w_prod);
                        if (r_sq_idx == 2'd2) begin
                            r_root  <= '0;
                            r_bit   <= SQ_W'(1) << 60;
                            r_state <= N_SQRT;
                        end else begin
                            r_sq_idx <= r_sq_idx + 2'd1;
                        end
                    end
                    N_SQRT: begin
                        if (w_sqrt_ge) begin
                            r_acc  <= r_acc - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        if (r_bit[0]) begin
                            r_comp  <= 2'd0;
                            r_state <= N_DIV_LOAD;
                        end
                    end
                    N_DIV_LOAD: begin
                        r_q <= '0;
                        if (w_vpos) begin
                            r_rem   <= w_num;
                            r_div   <= w_div_init;
                            r_k     <= KW'(NB - 1);
                            r_state <= N_DIV;
                        end else begin
                            r_state <= N_STORE;
                        end
                    end
                    N_DIV: begin
                        if (w_div_ge) begin
                            r_rem <= r_rem - r_div;
                        end
                        r_q   <= {r_q[NB-2:0], w_div_ge};
                        r_div <= r_div >> 1;
                        if (r_k == '0) begin
                            r_state <= N_STORE;
                        end else begin
                            r_k <= r_k - KW'(1);
                        end
                    end
                    N_STORE: begin
                        case (r_comp)
                            2'd0:    r_nx <= r_q;
                            2'd1:    r_ny <= r_q;
                            default: r_nz <= r_q;
                        endcase
                        if (r_comp == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= N_DIV_LOAD;
                        end
                    end
                    N_DONE: r_state <= N_DONE;
                    default: r_state <= N_IDLE;
                endcase
            end
        end
    end

    assign o_done = (r_state == N_DONE);
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;
    assign o_nz   = r_nz;

endmodule

@@ design/hnm_datapath.sv @@
// Datapath: position counters, line store, neighbour capture, job operand
// select, normal unit and output register. Uses hnm_pkg, hnm_ram, hnm_normal.
module hnm_datapath #(
    parameter int MAX_WIDTH   = hnm_pkg::MAX_WIDTH_DEF,
    parameter int HEIGHT_BITS = hnm_pkg::HEIGHT_BITS_DEF,
    parameter int NORMAL_BITS = hnm_pkg::NORMAL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hnm_pkg::t_cfg               i_cfg,
    input  hnm_pkg::t_cmd               i_cmd,
    output hnm_pkg::t_sts               o_sts,
    input  logic [HEIGHT_BITS-1:0]      i_height,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [NORMAL_BITS-1:0]      o_normal_x,
    output logic [NORMAL_BITS-1:0]      o_normal_y,
    output logic [NORMAL_BITS-1:0]      o_normal_z,
    output logic [hnm_pkg::COL_W-1:0]   o_out_col,
    output logic [hnm_pkg::ROW_W-1:0]   o_out_row,
    output logic                        o_last_of_item,
    output logic                        o_frame_done
);
    import hnm_pkg::*;

    localparam int HB = HEIGHT_BITS;
    localparam int NB = NORMAL_BITS;
    localparam int DW = HB + 1;
    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    r_col, r_x;
    logic [ROW_W-1:0] r_row, r_y;
    logic [HB-1:0]    r_h, r_prev, r_above, r_right;
    logic             r_end_row, r_last_row;

    logic [COL_W-1:0] r_pend_col;
    logic [ROW_W-1:0] r_pend_row;
    logic             r_pend_done, r_pend_last;

    logic             r_out_valid;
    logic [NB-1:0]    r_out_nx, r_out_ny, r_out_nz;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_last, r_out_done;

    logic [31:0]          w_w_eff, w_x_eff, w_rows_eff;
    logic [CW-1:0]        w_raddr;
    logic [HB-1:0]        w_rdata;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [31:0]          w_col32;
    logic [ROW_W-1:0]     w_row;
    logic                 w_done;
    logic                 w_norm_done;
    logic [NB-1:0]        w_nx, w_ny, w_nz;

    // Effective width/height and saturated column
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_w_eff = 32'd1;
        end else if (32'(i_cfg.frame_width) > 32'(MAX_WIDTH)) begin
            w_w_eff = 32'(MAX_WIDTH);
        end else begin
            w_w_eff = 32'(i_cfg.frame_width);
        end
        w_x_eff    = (32'(r_col) >= w_w_eff) ? (w_w_eff - 32'd1) : 32'(r_col);
        w_rows_eff = (i_cfg.frame_height == '0) ? 32'd1 : 32'(i_cfg.frame_height);
    end

    assign w_raddr = i_cmd.rd_next ? (r_x + CW'(1)) : r_x;

    hnm_ram #(
        .WIDTH (HB),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_back),
        .i_waddr (r_x),
        .i_wdata (r_h),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (i_cmd.job)
            JOB_ABOVE: begin
                w_dx    = r_end_row ? '0 :
                          ($signed({1'b0, r_right}) - $signed({1'b0, r_above}));
                w_dy    = $signed({1'b0, r_h}) - $signed({1'b0, r_above});
                w_col32 = 32'(r_x);
                w_row   = r_y - ROW_W'(1);
                w_done  = 1'b0;
            end
            JOB_LEFT: begin
                w_dx    = $signed({1'b0, r_h}) - $signed({1'b0, r_prev});
                w_dy    = '0;
                w_col32 = 32'(r_x - CW'(1));
                w_row   = r_y;
                w_done  = 1'b0;
            end
            default: begin
                w_dx    = '0;
                w_dy    = '0;
                w_col32 = 32'(r_x);
                w_row   = r_y;
                w_done  = 1'b1;
            end
        endcase
    end

    hnm_normal #(
        .HEIGHT_BITS (HB),
        .NORMAL_BITS (NB)
    ) u_normal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_dx     (w_dx),
        .i_dy     (w_dy),
        .i_gain_x (i_cfg.gain_x),
        .i_gain_y (i_cfg.gain_y),
        .o_done   (w_norm_done),
        .o_nx     (w_nx),
        .o_ny     (w_ny),
        .o_nz     (w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_x        <= w_x_eff[CW-1:0];
                r_y        <= r_row;
                r_h        <= i_height;
                r_end_row  <= (w_x_eff + 32'd1 >= w_w_eff);
                r_last_row <= (32'(r_row) + 32'd1 >= w_rows_eff);
            end
            if (i_cmd.cap_above) begin
                r_above <= w_rdata;
            end
            if (i_cmd.cap_right) begin
                r_right <= w_rdata;
            end
            if (i_cmd.start) begin
                r_pend_col  <= w_col32[COL_W-1:0];
                r_pend_row  <= w_row;
                r_pend_done <= w_done;
                r_pend_last <= i_cmd.last;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
                r_out_nx    <= w_nx;
                r_out_ny    <= w_ny;
                r_out_nz    <= w_nz;
                r_out_col   <= r_pend_col;
                r_out_row   <= r_pend_row;
                r_out_last  <= r_pend_last;
                r_out_done  <= r_pend_done;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.write_back) begin
                r_prev <= r_h;
                if (r_end_row) begin
                    r_col <= '0;
                    r_row <= r_last_row ? '0 : (r_y + ROW_W'(1));
                end else begin
                    r_col <= r_x + CW'(1);
                end
            end
        end
    end

    always_comb begin
        o_sts.has_above = (r_y != '0);
        o_sts.last_row  = r_last_row;
        o_sts.x_nonzero = (r_x != '0);
        o_sts.end_row   = r_end_row;
        o_sts.norm_done = w_norm_done;
        o_sts.out_free  = !r_out_valid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_normal_x     = r_out_nx;
    assign o_normal_y     = r_out_ny;
    assign o_normal_z     = r_out_nz;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;
    assign o_last_of_item = r_out_last;
    assign o_frame_done   = r_out_done;

endmodule

@@ design/hnm_ctrl.sv @@
// Controller: sequences line store reads, up to three normal jobs per item,
// result hand-off and write-back. Uses hnm_pkg.
module hnm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hnm_pkg::t_sts i_sts,
    output hnm_pkg::t_cmd o_cmd
);
    import hnm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_A, S_RD_B, S_CAP_B, S_JOB, S_WAIT, S_PUSH, S_WB
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_jobs, n_jobs;
    logic [2:0] w_pick;

    always_comb begin
        n_state = r_state;
        n_jobs  = r_jobs;
        o_cmd   = '0;
        o_cmd.job = JOB_CORNER;
        w_pick  = 3'b100;
        if (r_jobs[0]) begin
            w_pick = 3'b001;
        end else if (r_jobs[1]) begin
            w_pick = 3'b010;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD_A;
                end
            end
            S_RD_A: n_state = S_RD_B;
            S_RD_B: begin
                o_cmd.rd_next   = 1'b1;
                o_cmd.cap_above = 1'b1;
                n_state         = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.cap_right = 1'b1;
                // order: row above, delayed last-row pixel, final pixel
                n_jobs = {i_sts.last_row && i_sts.end_row,
                          i_sts.last_row && i_sts.x_nonzero,
                          i_sts.has_above};
                n_state = (n_jobs != 3'b000) ? S_JOB : S_WB;
            end
            S_JOB: begin
                o_cmd.start = 1'b1;
                if (w_pick[0]) begin
                    o_cmd.job = JOB_ABOVE;
                end else if (w_pick[1]) begin
                    o_cmd.job = JOB_LEFT;
                end
                n_jobs     = r_jobs & ~w_pick;
                o_cmd.last = (n_jobs == 3'b000);
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.norm_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = (r_jobs != 3'b000) ? S_JOB : S_WB;
                end
            end
            S_WB: begin
                o_cmd.write_back = 1'b1;
                n_state          = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_jobs  <= 3'b000;
        end else begin
            r_state <= n_state;
            r_jobs  <= n_jobs;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ design/hnm_checker.sv @@
// Port-level checker for the height map to normal map unit, bound to the top.
// Uses the assertion macros of heightmap_to_normalmap_unit_defines.svh.
`include "heightmap_to_normalmap_unit_defines.svh"

module hnm_checker #(
    parameter int OUT_DATA_W = 56
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic [0:0]            m_tuser
);

    // hold a stalled result
    `HNM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the final pixel of a frame is always the last result of its item
    `HNM_ASSERT_IMPLY(a_done_is_last, m_tvalid && m_tuser[0], m_tlast)

    // one item at a time: no accept in the cycle after an accept
    `HNM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind heightmap_to_normalmap_unit hnm_checker #(.OUT_DATA_W(OUT_DATA_W)) u_hnm_checker (.*);
